// File: sv/dssm_pkg.sv
// ----------------------------------------------------------------------------
// dssm_pkg - shared types and constants of the drum step sequencer mixer
// Holds opcodes, register indexes, sequencer states and store dimensions.
// ----------------------------------------------------------------------------
`default_nettype none

package dssm_pkg;

    // store dimensions
    localparam int INSTRUMENTS   = 16;
    localparam int STEPS         = 16;
    localparam int PATTERNS      = 16;
    localparam int SAMPLE_WORDS  = 16384;
    localparam int CHAIN_MAX     = 16;
    localparam int MIX_DIVISOR   = 6;

    // divide by six as a multiply by ceil(2^22 / 6) and a shift by 22;
    // exact for magnitudes up to 2^21
    localparam int MIX_RECIP     = 699051;
    localparam int MIX_SHIFT     = 22;

    // divider operand widths
    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 16;

    // register reset values
    localparam logic [15:0] BEAT_LEN_RST  = 16'd12000;
    localparam logic [4:0]  INST_CNT_RST  = 5'd16;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_TRIGGER = 3'd1,
        OP_TOGGLE  = 3'd2,
        OP_WR_SMP  = 3'd3,
        OP_SET_LEN = 3'd4,
        OP_WR_STEP = 3'd5,
        OP_APPEND  = 3'd6,
        OP_COMMIT  = 3'd7
    } t_op;

    typedef enum logic {
        CFG_BEAT_LEN  = 1'b0,
        CFG_INST_CNT  = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TDIV,
        ST_MDIV,
        ST_SDIV,
        ST_SWITCH,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_MIX_RD,
        ST_MIX_ACC,
        ST_VOICE_RD,
        ST_VOICE_ACC,
        ST_ODIV_GO,
        ST_ODIV,
        ST_OUT,
        ST_CDIV
    } t_state;

    // request to the shared divider
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_req;

    // answer of the shared divider
    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
        logic [DIV_DEN_W-1:0] remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

// File: sv/dssm_div.sv
// ----------------------------------------------------------------------------
// dssm_div - shared restoring divider
// Unsigned 32 by 16 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dssm_div (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  dssm_pkg::t_div_req i_req,
    output dssm_pkg::t_div_rsp o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [4:0]                     r_cnt;
    logic [dssm_pkg::DIV_NUM_W-1:0] r_quo;
    logic [dssm_pkg::DIV_DEN_W-1:0] r_rem;
    logic [dssm_pkg::DIV_DEN_W-1:0] r_dvs;

    logic [dssm_pkg::DIV_DEN_W:0]   w_shift;
    logic [dssm_pkg::DIV_DEN_W:0]   w_diff;
    logic                           w_fit;

    // shift in the next dividend bit and try a subtract
    always_comb begin
        w_shift = {r_rem, r_quo[dssm_pkg::DIV_NUM_W-1]};
        w_fit   = (w_shift >= {1'b0, r_dvs});
        w_diff  = w_shift - {1'b0, r_dvs};
    end

    // control: start, count, finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: load operands, then iterate
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[dssm_pkg::DIV_NUM_W-2:0], w_fit};
            r_rem <= w_fit ? w_diff[dssm_pkg::DIV_DEN_W-1:0]
                           : w_shift[dssm_pkg::DIV_DEN_W-1:0];
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

// File: sv/drum_step_sequencer_mixer.sv
// ----------------------------------------------------------------------------
// drum_step_sequencer_mixer - 16-step, 16-instrument drum sequencer and mixer
// Keeps patterns, a pattern chain and sample memories; mixes one sample a tick.
// ----------------------------------------------------------------------------
// A tick transaction runs the shared divider up to three times (tick over
// beat, switch mark over beat, pattern number over chain length, the last one
// only with a chain), then, while playing, a 16-step pattern sweep and a
// 16-instrument sweep of the pattern hits, and always a 16-instrument sweep of
// the playing voices, each entry read from memory with a registered read; the
// sum over six is a reciprocal multiply and then a saturation. Its result is
// offered once the receiver has taken the previous result. A commit while
// stopped with a pending chain also runs the divider; every other transaction
// is done as it is accepted. The input is not ready while a transaction is
// in work. There is no clearing pass: pattern rows carry valid bits, and
// sample words are undefined until written.
`default_nettype none

module drum_step_sequencer_mixer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration write port
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire  [15:0] i_cfg_data,
    // input items
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // op[2:0], instrument[6:3], address[20:7], sample_value[36:21],
    // sample_length[51:37], pattern[55:52], step[59:56], step_mask[75:60]
    input  wire  [79:0] s_axis_tdata,
    // result items
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // audio_sample[15:0], beat_index[19:16], playing[20], active_pat[24:21]
    output logic [31:0] m_axis_tdata
);

    // input fields
    logic [2:0]         w_op;
    logic [3:0]         w_instr;
    logic [13:0]        w_addr;
    logic signed [15:0] w_svalue;
    logic [14:0]        w_slen;
    logic [3:0]         w_pat;
    logic [3:0]         w_step;
    logic [15:0]        w_mask;

    assign w_op     = s_axis_tdata[2:0];
    assign w_instr  = s_axis_tdata[6:3];
    assign w_addr   = s_axis_tdata[20:7];
    assign w_svalue = s_axis_tdata[36:21];
    assign w_slen   = s_axis_tdata[51:37];
    assign w_pat    = s_axis_tdata[55:52];
    assign w_step   = s_axis_tdata[59:56];
    assign w_mask   = s_axis_tdata[75:60];

    dssm_pkg::t_state r_state, n_state;

    // configuration
    logic [15:0] r_beat_len;
    logic [4:0]  r_inst_cnt;

    // sequencer state
    logic [31:0] r_tick;
    logic [15:0] r_pulse;
    logic        r_run;
    logic [3:0]  r_chain [dssm_pkg::CHAIN_MAX];
    logic [4:0]  r_chain_len;
    logic [3:0]  r_pend [dssm_pkg::CHAIN_MAX];
    logic [4:0]  r_pend_len;
    logic        r_sw_valid;
    logic [31:0] r_sw_mark;

    // instrument state
    logic [14:0] r_len    [dssm_pkg::INSTRUMENTS];
    logic [15:0] r_loaded;
    logic [15:0] r_active;
    logic [13:0] r_pos    [dssm_pkg::INSTRUMENTS];

    // per-tick working registers
    logic [31:0]        r_qt;
    logic [15:0]        r_rt;
    logic [3:0]         r_cur_beat;
    logic [3:0]         r_cur_pat;
    logic               r_sw_due;
    logic [19:0]        r_off;
    logic [15:0]        r_hit;
    logic [13:0]        r_hit_off [dssm_pkg::INSTRUMENTS];
    logic [3:0]         r_idx;
    logic signed [20:0] r_sum;
    logic               r_neg;
    logic [18:0]        r_q6;
    logic [15:0]        r_audio;

    // output register
    logic        r_m_valid;
    logic [31:0] r_m_data;

    // memories
    logic [15:0]  r_pat_mem [256];
    logic [255:0] r_pat_vld;
    logic [15:0]  r_pat_rd;
    logic         r_pat_rd_vld;
    logic [15:0]  r_smp_mem [dssm_pkg::INSTRUMENTS * dssm_pkg::SAMPLE_WORDS];
    logic signed [15:0] r_smp_rd;

    dssm_pkg::t_div_req w_div_req;
    dssm_pkg::t_div_rsp w_div_rsp;

    logic        w_accept;
    logic [15:0] w_beat;
    logic [4:0]  w_voices;
    logic [15:0] w_pulse_adj;
    logic [20:0] w_mag;
    logic [40:0] w_q6_prod;
    logic [15:0] w_row;
    logic [14:0] w_pos_nx;
    logic [17:0] w_smp_raddr;
    logic [7:0]  w_pat_raddr;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_beat   = (r_beat_len == 16'd0) ? 16'd1 : r_beat_len;
    assign w_voices = (r_inst_cnt > 5'd16) ? 5'd16 : r_inst_cnt;
    assign w_pulse_adj = (r_pulse >= w_beat) ? (r_pulse - w_beat) : r_pulse;
    assign w_mag    = r_sum[20] ? (21'd0 - r_sum) : r_sum;
    assign w_q6_prod = 41'(w_mag) * 41'(dssm_pkg::MIX_RECIP);
    assign w_row    = r_pat_rd_vld ? r_pat_rd : 16'd0;
    assign w_pos_nx = {1'b0, r_pos[r_idx]} + 15'd1;
    assign w_pat_raddr = {r_cur_pat, r_cur_beat - r_idx};
    assign w_smp_raddr = (r_state == dssm_pkg::ST_MIX_RD) ? {r_idx, r_hit_off[r_idx]}
                                                          : {r_idx, r_pos[r_idx]};

    dssm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dssm_pkg::ST_IDLE: begin
                if (w_accept && (w_op == dssm_pkg::OP_TICK))
                    n_state = dssm_pkg::ST_TDIV;
                else if (w_accept && (w_op == dssm_pkg::OP_COMMIT) &&
                         (r_pend_len != 5'd0) && !r_run)
                    n_state = dssm_pkg::ST_CDIV;
            end
            dssm_pkg::ST_TDIV:
                if (w_div_rsp.done) n_state = dssm_pkg::ST_MDIV;
            dssm_pkg::ST_MDIV: begin
                if (w_div_rsp.done)
                    n_state = (r_chain_len != 5'd0) ? dssm_pkg::ST_SDIV
                                                    : dssm_pkg::ST_SWITCH;
            end
            dssm_pkg::ST_SDIV:
                if (w_div_rsp.done) n_state = dssm_pkg::ST_SWITCH;
            dssm_pkg::ST_SWITCH:
                n_state = r_run ? dssm_pkg::ST_SCAN_RD : dssm_pkg::ST_VOICE_RD;
            dssm_pkg::ST_SCAN_RD:   n_state = dssm_pkg::ST_SCAN_CHK;
            dssm_pkg::ST_SCAN_CHK:
                n_state = (r_idx == 4'd15) ? dssm_pkg::ST_MIX_RD : dssm_pkg::ST_SCAN_RD;
            dssm_pkg::ST_MIX_RD:    n_state = dssm_pkg::ST_MIX_ACC;
            dssm_pkg::ST_MIX_ACC:
                n_state = (r_idx == 4'd15) ? dssm_pkg::ST_VOICE_RD : dssm_pkg::ST_MIX_RD;
            dssm_pkg::ST_VOICE_RD:  n_state = dssm_pkg::ST_VOICE_ACC;
            dssm_pkg::ST_VOICE_ACC:
                n_state = (r_idx == 4'd15) ? dssm_pkg::ST_ODIV_GO : dssm_pkg::ST_VOICE_RD;
            dssm_pkg::ST_ODIV_GO:   n_state = dssm_pkg::ST_ODIV;
            dssm_pkg::ST_ODIV:      n_state = dssm_pkg::ST_OUT;
            dssm_pkg::ST_OUT:
                if (!r_m_valid || m_axis_tready) n_state = dssm_pkg::ST_IDLE;
            dssm_pkg::ST_CDIV:
                if (w_div_rsp.done) n_state = dssm_pkg::ST_IDLE;
            default: n_state = dssm_pkg::ST_IDLE;
        endcase
    end

    // outputs: ready and divider requests
    always_comb begin
        s_axis_tready      = (r_state == dssm_pkg::ST_IDLE);
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_tick;
        w_div_req.divisor  = w_beat;
        case (r_state)
            dssm_pkg::ST_IDLE: begin
                if (w_accept && (w_op == dssm_pkg::OP_TICK))
                    w_div_req.start = 1'b1;
                else if (w_accept && (w_op == dssm_pkg::OP_COMMIT) &&
                         (r_pend_len != 5'd0) && !r_run)
                    w_div_req.start = 1'b1;
            end
            dssm_pkg::ST_TDIV: begin
                w_div_req.start    = w_div_rsp.done;
                w_div_req.dividend = r_sw_mark;
            end
            dssm_pkg::ST_MDIV: begin
                w_div_req.start    = w_div_rsp.done && (r_chain_len != 5'd0);
                w_div_req.dividend = {4'd0, r_qt[31:4]};
                w_div_req.divisor  = {11'd0, r_chain_len};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= dssm_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // control state, counters and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat_len  <= dssm_pkg::BEAT_LEN_RST;
            r_inst_cnt  <= dssm_pkg::INST_CNT_RST;
            r_tick      <= '0;
            r_pulse     <= '0;
            r_run       <= 1'b0;
            r_chain_len <= '0;
            r_pend_len  <= '0;
            r_sw_valid  <= 1'b0;
            r_sw_mark   <= '0;
            r_loaded    <= '0;
            r_active    <= '0;
            r_m_valid   <= 1'b0;
            for (int i = 0; i < dssm_pkg::INSTRUMENTS; i++) r_len[i] <= '0;
            for (int i = 0; i < dssm_pkg::CHAIN_MAX; i++) begin
                r_chain[i] <= '0;
                r_pend[i]  <= '0;
            end
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (dssm_pkg::t_cfg_idx'(i_cfg_index))
                    dssm_pkg::CFG_BEAT_LEN: r_beat_len <= i_cfg_data;
                    dssm_pkg::CFG_INST_CNT: r_inst_cnt <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            // drop the result once taken, unless a new one is loaded now
            if (r_m_valid && m_axis_tready && (r_state != dssm_pkg::ST_OUT))
                r_m_valid <= 1'b0;

            case (r_state)
                dssm_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        case (dssm_pkg::t_op'(w_op))
                            dssm_pkg::OP_TRIGGER: begin
                                if (({1'b0, w_instr} < w_voices) && r_loaded[w_instr]) begin
                                    r_active[w_instr] <= 1'b1;
                                    r_pos[w_instr]    <= '0;
                                end
                            end
                            dssm_pkg::OP_TOGGLE: begin
                                r_run <= !r_run;
                                if (r_run) begin
                                    r_tick  <= '0;
                                    r_pulse <= '0;
                                end
                            end
                            dssm_pkg::OP_SET_LEN: begin
                                r_len[w_instr]    <= (w_slen > 15'd16384) ? 15'd16384 : w_slen;
                                r_loaded[w_instr] <= (w_slen != 15'd0);
                            end
                            dssm_pkg::OP_APPEND: begin
                                if (r_pend_len < 5'd16) begin
                                    r_pend[r_pend_len[3:0]] <= w_pat;
                                    r_pend_len <= r_pend_len + 5'd1;
                                end
                            end
                            dssm_pkg::OP_COMMIT: begin
                                if ((r_pend_len != 5'd0) && r_run) begin
                                    r_sw_valid <= 1'b1;
                                    r_sw_mark  <= r_tick;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                dssm_pkg::ST_TDIV: begin
                    if (w_div_rsp.done) begin
                        r_qt       <= w_div_rsp.quotient;
                        r_rt       <= w_div_rsp.remainder;
                        r_cur_beat <= w_div_rsp.quotient[3:0];
                    end
                end
                dssm_pkg::ST_MDIV: begin
                    if (w_div_rsp.done) begin
                        r_sw_due  <= r_sw_valid && (w_div_rsp.quotient[31:4] < r_qt[31:4]);
                        r_cur_pat <= '0;
                    end
                end
                dssm_pkg::ST_SDIV: begin
                    if (w_div_rsp.done)
                        r_cur_pat <= r_chain[w_div_rsp.remainder[3:0]];
                end
                dssm_pkg::ST_SWITCH: begin
                    // install a due chain, then advance the counters
                    if (r_sw_due) begin
                        for (int i = 0; i < dssm_pkg::CHAIN_MAX; i++) r_chain[i] <= r_pend[i];
                        r_chain_len <= r_pend_len;
                        r_pend_len  <= '0;
                        r_sw_valid  <= 1'b0;
                    end
                    if (r_run) begin
                        r_tick  <= (r_sw_due ? {16'd0, r_rt} : r_tick) + 32'd1;
                        r_pulse <= w_pulse_adj + 16'd1;
                    end else if (r_sw_due) begin
                        r_tick <= {16'd0, r_rt};
                    end
                    r_off <= {4'd0, w_pulse_adj};
                    r_hit <= '0;
                    r_sum <= '0;
                    r_idx <= '0;
                end
                dssm_pkg::ST_SCAN_CHK: begin
                    // latch each instrument's latest hit still sounding
                    for (int k = 0; k < dssm_pkg::INSTRUMENTS; k++) begin
                        if (w_row[k] && !r_hit[k] && (r_off < {5'd0, r_len[k]})) begin
                            r_hit[k]     <= 1'b1;
                            r_hit_off[k] <= r_off[13:0];
                        end
                    end
                    r_off <= r_off + {4'd0, w_beat};
                    r_idx <= r_idx + 4'd1;
                end
                dssm_pkg::ST_MIX_ACC: begin
                    if (r_hit[r_idx]) r_sum <= r_sum + 21'(r_smp_rd);
                    r_idx <= r_idx + 4'd1;
                end
                dssm_pkg::ST_VOICE_ACC: begin
                    if (r_active[r_idx] && ({1'b0, r_idx} < w_voices)) begin
                        r_sum <= r_sum + 21'(r_smp_rd);
                        if (w_pos_nx >= r_len[r_idx]) r_active[r_idx] <= 1'b0;
                        else                           r_pos[r_idx]    <= w_pos_nx[13:0];
                    end
                    r_idx <= r_idx + 4'd1;
                end
                dssm_pkg::ST_ODIV_GO: begin
                    // divide the magnitude by six
                    r_neg <= r_sum[20];
                    r_q6  <= w_q6_prod[40:dssm_pkg::MIX_SHIFT];
                end
                dssm_pkg::ST_ODIV: begin
                    // saturate the truncated quotient
                    if (!r_neg && (r_q6 > 19'd32767))
                        r_audio <= 16'h7FFF;
                    else if (r_neg && (r_q6 > 19'd32768))
                        r_audio <= 16'h8000;
                    else if (r_neg)
                        r_audio <= 16'd0 - r_q6[15:0];
                    else
                        r_audio <= r_q6[15:0];
                end
                dssm_pkg::ST_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {7'd0, r_cur_pat, r_run, r_cur_beat, r_audio};
                    end
                end
                dssm_pkg::ST_CDIV: begin
                    if (w_div_rsp.done) begin
                        for (int i = 0; i < dssm_pkg::CHAIN_MAX; i++) r_chain[i] <= r_pend[i];
                        r_chain_len <= r_pend_len;
                        r_pend_len  <= '0;
                        r_sw_valid  <= 1'b0;
                        r_tick      <= {16'd0, w_div_rsp.remainder};
                    end
                end
                default: ;
            endcase
        end
    end

    // pattern store: valid bit per row, registered read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_vld <= '0;
        end else if (w_accept && (w_op == dssm_pkg::OP_WR_STEP)) begin
            r_pat_vld[{w_pat, w_step}] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (w_op == dssm_pkg::OP_WR_STEP))
            r_pat_mem[{w_pat, w_step}] <= w_mask;
        r_pat_rd     <= r_pat_mem[w_pat_raddr];
        r_pat_rd_vld <= r_pat_vld[w_pat_raddr];
    end

    // sample store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_op == dssm_pkg::OP_WR_SMP))
            r_smp_mem[{w_instr, w_addr}] <= w_svalue;
        r_smp_rd <= r_smp_mem[w_smp_raddr];
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire

// File: sv/dssm_chk.sv
// ----------------------------------------------------------------------------
// dssm_chk - port checker for the drum step sequencer mixer
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module dssm_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire [79:0] s_axis_tdata,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // a tick transaction keeps the input busy
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata[2:0] == dssm_pkg::OP_TICK)
        |=> !s_axis_tready)
        else $error("input ready right after a tick transaction");

    // a new result appears only out of a busy period
    a_out_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without a tick in work");

    // ready after reset
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind drum_step_sequencer_mixer dssm_chk u_dssm_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
